// ===== sv/stock_span_monotonic_stack_assert.svh =====
// ----------------------------------------------------------------------------
// Stock span assertion macros
// Shared property forms for the stock span unit, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STOCK_SPAN_MONOTONIC_STACK_ASSERT_SVH
`define STOCK_SPAN_MONOTONIC_STACK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stock span check failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define SSMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stock span check failed: next-cycle property");

`endif

// ===== sv/stkspan_pkg.sv =====
// ----------------------------------------------------------------------------
// Stock span package
// Sizes, types and the control store of the stock span sequencer.
// ----------------------------------------------------------------------------
package stkspan_pkg;

    localparam int MAX_DAYS   = 1024;
    localparam int PRICE_BITS = 32;
    localparam int PRICE_W    = 32;
    localparam int SPAN_W     = 11;
    localparam int DAY_BITS   = $clog2(MAX_DAYS);
    localparam int DEPTH_BITS = DAY_BITS + 1;

    typedef logic signed [PRICE_BITS-1:0] price_t;
    typedef logic [DAY_BITS-1:0]          day_t;
    typedef logic [DEPTH_BITS-1:0]        depth_t;
    typedef logic [SPAN_W-1:0]            span_t;

    // Step counter of the sequencer.
    typedef logic [0:0] step_t;
    localparam step_t STEP_FETCH = 1'b0;
    localparam step_t STEP_SCAN  = 1'b1;

    // Condition that lets the program leave the current step.
    typedef enum logic [1:0] {
        COND_STAY     = 2'b01,
        COND_TRANSFER = 2'b10
    } cond_e;

    typedef enum logic [1:0] {
        LEAVE_ON_NONE   = 2'b01,
        LEAVE_ON_RETIRE = 2'b10
    } retire_e;

    typedef struct packed {
        logic    take;    // offer ready on the input channel
        logic    scan;    // compare, pop, or retire the held item
        cond_e   cond;    // leave the step on an input transfer
        retire_e retire;  // leave the step once the item retires
        step_t   target;  // step taken when the condition holds
    } ctrl_t;

    function automatic ctrl_t ucode_rom(step_t s);
        ctrl_t w;
        w = '{take: 1'b0, scan: 1'b0, cond: COND_STAY, retire: LEAVE_ON_NONE,
              target: STEP_FETCH};
        case (s)
            STEP_FETCH:
            begin
                w = '{take: 1'b1, scan: 1'b0, cond: COND_TRANSFER,
                      retire: LEAVE_ON_NONE, target: STEP_SCAN};
            end
            STEP_SCAN:
            begin
                w = '{take: 1'b0, scan: 1'b1, cond: COND_STAY,
                      retire: LEAVE_ON_RETIRE, target: STEP_FETCH};
            end
            default:
            begin
                w = '{take: 1'b0, scan: 1'b0, cond: COND_STAY,
                      retire: LEAVE_ON_NONE, target: STEP_FETCH};
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/stkspan_if.sv =====
// ----------------------------------------------------------------------------
// Stock span channels
// Valid/ready channels for daily prices and for span results.
// ----------------------------------------------------------------------------
interface stkspan_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [stkspan_pkg::PRICE_W-1:0] price;
    logic                               last_day;

    modport source (output valid, output price, output last_day, input ready);
    modport sink (input valid, input price, input last_day, output ready);
endinterface

interface stkspan_out_if;
    logic                        valid;
    logic                        ready;
    logic [stkspan_pkg::SPAN_W-1:0] span;
    logic                        overflow;

    modport source (output valid, output span, output overflow, input ready);
    modport sink (input valid, input span, input overflow, output ready);
endinterface

// ===== sv/stock_span_monotonic_stack.sv =====
// A result is registered when its price retires from the scan step, after every stack
// entry that the new price pops; a full output register can hold it back.
// A new price is taken only after the previous one has retired; the single
// read port of the stack memory pops one entry per cycle.
// Reset clears the step counter, stack depth, day count and output valid at once;
// the stack memories are not cleared, since only entries below the depth are used.
// ----------------------------------------------------------------------------
// Stock span unit
// Returns for each daily price the distance back to the nearest earlier day
// of greater or equal price, using a monotonic stack driven by a microcoded
// sequencer.
// ----------------------------------------------------------------------------
`include "stock_span_monotonic_stack_assert.svh"

module stock_span_monotonic_stack (
    input  logic                 clk,
    input  logic                 rst_n,
    stkspan_in_if.sink           prices,
    stkspan_out_if.source        spans
);

    stkspan_pkg::ctrl_t   ctrl;
    stkspan_pkg::step_t   step_reg, step_next;

    stkspan_pkg::depth_t  depth_reg, depth_next;
    stkspan_pkg::depth_t  day_count_reg, day_count_next;

    stkspan_pkg::price_t  key_reg;
    logic                 last_reg;
    logic                 item_ovf_reg;

    stkspan_pkg::price_t  price_mem [stkspan_pkg::MAX_DAYS];
    stkspan_pkg::day_t    day_mem   [stkspan_pkg::MAX_DAYS];
    stkspan_pkg::price_t  top_price_reg;
    stkspan_pkg::day_t    top_day_reg;
    stkspan_pkg::day_t    rd_addr;
    stkspan_pkg::day_t    wr_addr;

    logic                 out_valid_reg;
    stkspan_pkg::span_t   span_reg, span_next;
    logic                 overflow_reg;

    logic                 xfer_in;
    logic                 out_free;
    logic                 pop;
    logic                 retire;
    logic                 push;

    assign ctrl     = stkspan_pkg::ucode_rom(step_reg);
    assign xfer_in  = ctrl.take && prices.valid;
    assign out_free = !out_valid_reg || spans.ready;

    // Pop while the top of the stack holds a strictly lower price.
    assign pop    = ctrl.scan && !item_ovf_reg && (depth_reg != '0)
                    && (top_price_reg < key_reg);
    assign retire = ctrl.scan && !pop && out_free;
    assign push   = retire && !item_ovf_reg;

    assign prices.ready   = ctrl.take;
    assign spans.valid    = out_valid_reg;
    assign spans.span     = span_reg;
    assign spans.overflow = overflow_reg;

    always_comb
    begin
        step_next = step_reg;
        case (ctrl.cond)
            stkspan_pkg::COND_TRANSFER:
            begin
                if (xfer_in)
                begin
                    step_next = ctrl.target;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
        case (ctrl.retire)
            stkspan_pkg::LEAVE_ON_RETIRE:
            begin
                if (retire)
                begin
                    step_next = ctrl.target;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        depth_next     = depth_reg;
        day_count_next = day_count_reg;
        if (pop)
        begin
            depth_next = depth_reg - 1'b1;
        end
        if (push)
        begin
            depth_next     = depth_reg + 1'b1;
            day_count_next = day_count_reg + 1'b1;
        end
        if (retire && last_reg)
        begin
            depth_next     = '0;
            day_count_next = '0;
        end
    end

    always_comb
    begin
        if (item_ovf_reg)
        begin
            span_next = '0;
        end
        else if (depth_reg == '0)
        begin
            span_next = stkspan_pkg::SPAN_W'(day_count_reg + 1'b1);
        end
        else
        begin
            span_next = stkspan_pkg::SPAN_W'(day_count_reg
                        - {1'b0, top_day_reg});
        end
    end

    // The top is read from the depth that the stack has after this cycle.
    assign rd_addr = stkspan_pkg::DAY_BITS'(depth_next - 1'b1);
    assign wr_addr = depth_reg[stkspan_pkg::DAY_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            price_mem[wr_addr] <= key_reg;
            day_mem[wr_addr]   <= day_count_reg[stkspan_pkg::DAY_BITS-1:0];
        end
        top_price_reg <= price_mem[rd_addr];
        top_day_reg   <= day_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (xfer_in)
        begin
            key_reg      <= prices.price[stkspan_pkg::PRICE_BITS-1:0];
            last_reg     <= prices.last_day;
            item_ovf_reg <= (day_count_reg == stkspan_pkg::DEPTH_BITS'(stkspan_pkg::MAX_DAYS));
        end
        if (retire)
        begin
            span_reg     <= span_next;
            overflow_reg <= item_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= stkspan_pkg::STEP_FETCH;
            depth_reg     <= '0;
            day_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            depth_reg     <= depth_next;
            day_count_reg <= day_count_next;
            if (retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (spans.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `SSMS_ASSERT_SAME(a_depth_within_days, 1'b1, depth_reg <= day_count_reg)
    `SSMS_ASSERT_SAME(a_days_bounded, 1'b1,
        day_count_reg <= stkspan_pkg::DEPTH_BITS'(stkspan_pkg::MAX_DAYS))
    `SSMS_ASSERT_NEXT(a_pop_one_entry, pop, depth_reg == $past(depth_reg) - 1'b1)
    `SSMS_ASSERT_SAME(a_overflow_zero_span, out_valid_reg && overflow_reg, span_reg == '0)
    `SSMS_ASSERT_NEXT(a_retire_shows_result, retire, out_valid_reg)

endmodule
